[rtl/csps_pkg.sv]
// types, constants and microcode table of the cross spectrum power smoother
package csps_pkg;

	localparam int IDX_W      = 16;
	localparam int CROSS_W    = 33;
	localparam int POW_W      = 48;
	localparam int WGT_W      = 16;
	localparam int SHIFT_W    = 6;
	localparam int OPND_W     = 34;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int ACC_W      = PROD_W;
	localparam int SQSUM_W    = 66;
	localparam int FRAC_BITS  = 15;
	localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
	localparam int HALF_W     = 32;
	localparam int STEP_W     = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	localparam logic [SHIFT_W-1:0] POWER_SHIFT_RST   = 6'd40;
	localparam logic               SMOOTH_ENABLE_RST = 1'b1;
	localparam logic [WGT_W-1:0]   SIDE_WEIGHT_RST   = 16'd2114;
	localparam logic [WGT_W-1:0]   CENTER_WEIGHT_RST = 16'd28541;

	localparam logic [STEP_W-1:0] STEP_EMIT = 5'd16;

	typedef enum logic [1:0] {
		REG_POWER_SHIFT   = 2'd0,
		REG_SMOOTH_ENABLE = 2'd1,
		REG_SIDE_WEIGHT   = 2'd2,
		REG_CENTER_WEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		MS_ARE_BRE  = 4'd0,
		MS_AIM_BIM  = 4'd1,
		MS_AIM_BRE  = 4'd2,
		MS_ARE_BIM  = 4'd3,
		MS_SQ_CR    = 4'd4,
		MS_SQ_CI    = 4'd5,
		MS_PREV_LO  = 4'd6,
		MS_PREV_HI  = 4'd7,
		MS_HELD_LO  = 4'd8,
		MS_HELD_HI  = 4'd9,
		MS_RP_LO    = 4'd10,
		MS_RP_HI    = 4'd11
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD   = 3'd0,
		ACC_LOAD   = 3'd1,
		ACC_ADD    = 3'd2,
		ACC_SUB    = 3'd3,
		ACC_ADD_HI = 3'd4
	} acc_op_t;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_CR   = 3'd1,
		ST_CI   = 3'd2,
		ST_RP   = 3'd3,
		ST_SM   = 3'd4
	} store_t;

	typedef enum logic [1:0] {
		EM_NONE = 2'd0,
		EM_HELD = 2'd1,
		EM_NEW  = 2'd2
	} emit_t;

	typedef enum logic {
		JMP_NONE      = 1'b0,
		JMP_NO_SMOOTH = 1'b1
	} jump_t;

	typedef struct packed {
		mul_sel_t          mul;
		acc_op_t           acc;
		store_t            st;
		emit_t             em;
		jump_t             jmp;
		logic [STEP_W-1:0] target;
		logic              fin;
	} ucode_t;

	typedef struct packed {
		mul_sel_t mul;
		acc_op_t  acc;
		store_t   st;
		emit_t    em;
		logic     commit;
	} csps_ctl_t;

	typedef struct packed {
		logic do_smooth;
		logic holding;
		logic final_bin;
		logic out_busy;
	} csps_status_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] power_shift;
		logic               smooth_enable;
		logic [WGT_W-1:0]   side_weight;
		logic [WGT_W-1:0]   center_weight;
	} csps_cfg_t;

	// microcode: the product of step k is accumulated at step k+1
	function automatic ucode_t ucode(input logic [STEP_W-1:0] s);
		ucode_t w;
		w.mul    = MS_ARE_BRE;
		w.acc    = ACC_HOLD;
		w.st     = ST_NONE;
		w.em     = EM_NONE;
		w.jmp    = JMP_NONE;
		w.target = '0;
		w.fin    = 1'b0;
		case (s)
			5'd0: begin
				w.mul = MS_ARE_BRE;
			end
			5'd1: begin
				w.mul = MS_AIM_BIM;
				w.acc = ACC_LOAD;
			end
			5'd2: begin
				w.mul = MS_AIM_BRE;
				w.acc = ACC_ADD;
			end
			5'd3: begin
				w.mul = MS_ARE_BIM;
				w.acc = ACC_LOAD;
				w.st  = ST_CR;
			end
			5'd4: begin
				w.mul = MS_SQ_CR;
				w.acc = ACC_SUB;
			end
			5'd5: begin
				w.acc = ACC_LOAD;
				w.st  = ST_CI;
			end
			5'd6: begin
				w.mul = MS_SQ_CI;
			end
			5'd7: begin
				w.acc = ACC_ADD;
			end
			5'd8: begin
				w.mul    = MS_PREV_LO;
				w.st     = ST_RP;
				w.jmp    = JMP_NO_SMOOTH;
				w.target = STEP_EMIT;
			end
			5'd9: begin
				w.mul = MS_PREV_HI;
				w.acc = ACC_LOAD;
			end
			5'd10: begin
				w.mul = MS_HELD_LO;
				w.acc = ACC_ADD_HI;
			end
			5'd11: begin
				w.mul = MS_HELD_HI;
				w.acc = ACC_ADD;
			end
			5'd12: begin
				w.mul = MS_RP_LO;
				w.acc = ACC_ADD_HI;
			end
			5'd13: begin
				w.mul = MS_RP_HI;
				w.acc = ACC_ADD;
			end
			5'd14: begin
				w.acc = ACC_ADD_HI;
			end
			5'd15: begin
				w.st = ST_SM;
			end
			5'd16: begin
				w.em = EM_HELD;
			end
			5'd17: begin
				w.em  = EM_NEW;
				w.fin = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/csps_seq.sv]
// microcode sequencer: step counter, control store and conditional jump
module csps_seq
	import csps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  csps_status_t status,
	output logic         busy,
	output csps_ctl_t    ctl
);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	ucode_t            word;
	logic              emit_needed;
	logic              run;

	assign word = ucode(step_q);

	// an emit step with a word to write waits while the output word is still held up
	assign emit_needed = (word.em == EM_HELD && status.holding)
		|| (word.em == EM_NEW && status.final_bin);
	assign run = busy_q && !(emit_needed && status.out_busy);

	always_comb begin
		ctl.mul    = word.mul;
		ctl.acc    = run ? word.acc : ACC_HOLD;
		ctl.st     = run ? word.st : ST_NONE;
		ctl.em     = (run && emit_needed) ? word.em : EM_NONE;
		ctl.commit = run && word.fin;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (run) begin
			if (word.fin) begin
				step_q <= '0;
				busy_q <= 1'b0;
			end else if (word.jmp == JMP_NO_SMOOTH && !status.do_smooth) begin
				step_q <= word.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

[rtl/csps_dp.sv]
// datapath: shared multiplier, accumulator, bin state and output word register
module csps_dp
	import csps_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int MAX_BINS     = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SAMPLE_WIDTH-1:0] first_re,
	input  logic signed [SAMPLE_WIDTH-1:0] first_im,
	input  logic signed [SAMPLE_WIDTH-1:0] second_re,
	input  logic signed [SAMPLE_WIDTH-1:0] second_im,
	input  logic                           final_bin,
	input  csps_cfg_t                      cfg,
	input  csps_ctl_t                      ctl,
	input  logic                           result_stall,
	output csps_status_t                   status,
	output logic                           result_valid,
	output logic [IDX_W-1:0]               bin_index,
	output logic signed [CROSS_W-1:0]      cross_re,
	output logic signed [CROSS_W-1:0]      cross_im,
	output logic [POW_W-1:0]               power,
	output logic                           last
);

	localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam logic [BIN_W-1:0] BIN_TOP = BIN_W'(MAX_BINS - 1);
	localparam int SMQ_W = ACC_W - FRAC_BITS;

	logic signed [SAMPLE_WIDTH-1:0] are_q, aim_q, bre_q, bim_q;
	logic                           final_q;

	logic signed [OPND_W-1:0] opa, opb;
	logic [PROD_W-1:0]        prod_q;
	logic [ACC_W-1:0]         acc_q;

	logic signed [CROSS_W-1:0] cr_q, ci_q;
	logic [POW_W-1:0]          rp_q, sm_q;
	logic signed [CROSS_W-1:0] held_cr_q, held_ci_q;
	logic [POW_W-1:0]          held_rp_q, prior_q;
	logic                      holding_q;
	logic [BIN_W-1:0]          cnt_q;
	logic [BIN_W-1:0]          next_idx;

	logic signed [OPND_W-1:0] cr_ext, ci_ext, cr_mag, ci_mag;
	logic [SQSUM_W-1:0]       sq_shifted;
	logic [POW_W-1:0]         rp_sat;
	logic [ACC_W-1:0]         acc_rnd;
	logic [SMQ_W-1:0]         sm_q53;
	logic [POW_W-1:0]         sm_sat;
	logic [POW_W-1:0]         held_pw;

	logic                      res_valid_q;
	logic [IDX_W-1:0]          res_idx_q;
	logic signed [CROSS_W-1:0] res_re_q, res_im_q;
	logic [POW_W-1:0]          res_pw_q;
	logic                      res_last_q;

	// magnitudes of the wrapped cross parts, up to 2^32
	assign cr_ext = OPND_W'(cr_q);
	assign ci_ext = OPND_W'(ci_q);
	assign cr_mag = cr_ext[OPND_W-1] ? -cr_ext : cr_ext;
	assign ci_mag = ci_ext[OPND_W-1] ? -ci_ext : ci_ext;

	always_comb begin
		case (ctl.mul)
			MS_ARE_BRE: begin
				opa = OPND_W'(are_q);
				opb = OPND_W'(bre_q);
			end
			MS_AIM_BIM: begin
				opa = OPND_W'(aim_q);
				opb = OPND_W'(bim_q);
			end
			MS_AIM_BRE: begin
				opa = OPND_W'(aim_q);
				opb = OPND_W'(bre_q);
			end
			MS_ARE_BIM: begin
				opa = OPND_W'(are_q);
				opb = OPND_W'(bim_q);
			end
			MS_SQ_CR: begin
				opa = cr_mag;
				opb = cr_mag;
			end
			MS_SQ_CI: begin
				opa = ci_mag;
				opb = ci_mag;
			end
			MS_PREV_LO: begin
				opa = OPND_W'(prior_q[HALF_W-1:0]);
				opb = OPND_W'(cfg.side_weight);
			end
			MS_PREV_HI: begin
				opa = OPND_W'(prior_q[POW_W-1:HALF_W]);
				opb = OPND_W'(cfg.side_weight);
			end
			MS_HELD_LO: begin
				opa = OPND_W'(held_rp_q[HALF_W-1:0]);
				opb = OPND_W'(cfg.center_weight);
			end
			MS_HELD_HI: begin
				opa = OPND_W'(held_rp_q[POW_W-1:HALF_W]);
				opb = OPND_W'(cfg.center_weight);
			end
			MS_RP_LO: begin
				opa = OPND_W'(rp_q[HALF_W-1:0]);
				opb = OPND_W'(cfg.side_weight);
			end
			MS_RP_HI: begin
				opa = OPND_W'(rp_q[POW_W-1:HALF_W]);
				opb = OPND_W'(cfg.side_weight);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// scaled power: truncating shift, then saturate
	assign sq_shifted = acc_q[SQSUM_W-1:0] >> cfg.power_shift;
	assign rp_sat = (|sq_shifted[SQSUM_W-1:POW_W]) ? '1 : sq_shifted[POW_W-1:0];

	// smoothed power: round half up at the Q15 point, then saturate
	assign acc_rnd = acc_q + ACC_W'(ROUND_BIAS);
	assign sm_q53  = acc_rnd[ACC_W-1:FRAC_BITS];
	assign sm_sat  = (|sm_q53[SMQ_W-1:POW_W]) ? '1 : sm_q53[POW_W-1:0];

	assign next_idx = holding_q ? ((cnt_q == BIN_TOP) ? '0 : cnt_q + 1'b1) : cnt_q;
	assign held_pw  = status.do_smooth ? sm_q : held_rp_q;

	always_comb begin
		status.do_smooth = holding_q && cfg.smooth_enable && (cnt_q != '0);
		status.holding   = holding_q;
		status.final_bin = final_q;
		status.out_busy  = res_valid_q && result_stall;
	end

	// operands, products and working values
	always_ff @(posedge clk) begin
		if (start) begin
			are_q   <= first_re;
			aim_q   <= first_im;
			bre_q   <= second_re;
			bim_q   <= second_im;
			final_q <= final_bin;
		end
		prod_q <= opa * opb;
		case (ctl.acc)
			ACC_HOLD:   acc_q <= acc_q;
			ACC_LOAD:   acc_q <= prod_q;
			ACC_ADD:    acc_q <= acc_q + prod_q;
			ACC_SUB:    acc_q <= acc_q - prod_q;
			ACC_ADD_HI: acc_q <= acc_q + (prod_q << HALF_W);
			default:    acc_q <= acc_q;
		endcase
		case (ctl.st)
			ST_NONE: ;
			ST_CR:   cr_q <= acc_q[CROSS_W-1:0];
			ST_CI:   ci_q <= acc_q[CROSS_W-1:0];
			ST_RP:   rp_q <= rp_sat;
			ST_SM:   sm_q <= sm_sat;
			default: ;
		endcase
		case (ctl.em)
			EM_NONE: ;
			EM_HELD: begin
				res_idx_q  <= IDX_W'(cnt_q);
				res_re_q   <= held_cr_q;
				res_im_q   <= held_ci_q;
				res_pw_q   <= held_pw;
				res_last_q <= 1'b0;
			end
			EM_NEW: begin
				res_idx_q  <= IDX_W'(next_idx);
				res_re_q   <= cr_q;
				res_im_q   <= ci_q;
				res_pw_q   <= rp_q;
				res_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// bin state carried from one item to the next, and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cr_q   <= '0;
			held_ci_q   <= '0;
			held_rp_q   <= '0;
			prior_q     <= '0;
			holding_q   <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.em != EM_NONE) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (ctl.em == EM_HELD) begin
				prior_q <= held_pw;
			end
			if (ctl.commit) begin
				if (final_q) begin
					held_cr_q <= '0;
					held_ci_q <= '0;
					held_rp_q <= '0;
					prior_q   <= '0;
					holding_q <= 1'b0;
					cnt_q     <= '0;
				end else begin
					held_cr_q <= cr_q;
					held_ci_q <= ci_q;
					held_rp_q <= rp_q;
					holding_q <= 1'b1;
					cnt_q     <= next_idx;
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign bin_index    = res_idx_q;
	assign cross_re     = res_re_q;
	assign cross_im     = res_im_q;
	assign power        = res_pw_q;
	assign last         = res_last_q;

endmodule

[rtl/cross_spectrum_power_smoother_top.sv]
// top level: configuration registers, microcode sequencer and datapath
// the held bin's word is written at the emit step, after the smoothing steps when it is smoothed
// one bin at a time: a new bin is taken only once the program has finished, later under output stall
// the program length is set by the microcode around the one shared 34x34 multiplier
// reset: arst_n clears control and bin state, registers return to their defaults
// one output word register; a final bin adds its own word after the held bin's, once the register is free
module cross_spectrum_power_smoother_top
	import csps_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int MAX_BINS     = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] first_re,
	input  logic signed [SAMPLE_WIDTH-1:0] first_im,
	input  logic signed [SAMPLE_WIDTH-1:0] second_re,
	input  logic signed [SAMPLE_WIDTH-1:0] second_im,
	input  logic                           final_bin,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [IDX_W-1:0]               bin_index,
	output logic signed [CROSS_W-1:0]      cross_re,
	output logic signed [CROSS_W-1:0]      cross_im,
	output logic [POW_W-1:0]               power,
	output logic                           last,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [CFG_ADDR_W-1:0]          paddr,
	input  logic [CFG_DATA_W-1:0]          pwdata,
	output logic [CFG_DATA_W-1:0]          prdata,
	output logic                           pready
);

	csps_cfg_t    cfg_q;
	csps_ctl_t    ctl;
	csps_status_t status;
	logic         busy;
	logic         start;
	logic         cfg_wr;
	reg_idx_t     reg_idx;

	// one bin at a time: the next word is taken once the program has finished
	assign item_stall = busy;
	assign start      = item_valid && !busy;

	// registers sit on word addresses, byte lanes are ignored
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_shift   <= POWER_SHIFT_RST;
			cfg_q.smooth_enable <= SMOOTH_ENABLE_RST;
			cfg_q.side_weight   <= SIDE_WEIGHT_RST;
			cfg_q.center_weight <= CENTER_WEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_POWER_SHIFT:   cfg_q.power_shift   <= pwdata[SHIFT_W-1:0];
				REG_SMOOTH_ENABLE: cfg_q.smooth_enable <= pwdata[0];
				REG_SIDE_WEIGHT:   cfg_q.side_weight   <= pwdata[WGT_W-1:0];
				REG_CENTER_WEIGHT: cfg_q.center_weight <= pwdata[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero above each field
	always_comb begin
		case (reg_idx)
			REG_POWER_SHIFT:   prdata = CFG_DATA_W'(cfg_q.power_shift);
			REG_SMOOTH_ENABLE: prdata = CFG_DATA_W'(cfg_q.smooth_enable);
			REG_SIDE_WEIGHT:   prdata = CFG_DATA_W'(cfg_q.side_weight);
			REG_CENTER_WEIGHT: prdata = CFG_DATA_W'(cfg_q.center_weight);
			default:           prdata = '0;
		endcase
	end

	// step counter and control store
	csps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.ctl    (ctl)
	);

	// cross spectrum, power, smoothing and output word register
	csps_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_BINS     (MAX_BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.first_re     (first_re),
		.first_im     (first_im),
		.second_re    (second_re),
		.second_im    (second_im),
		.final_bin    (final_bin),
		.cfg          (cfg_q),
		.ctl          (ctl),
		.result_stall (result_stall),
		.status       (status),
		.result_valid (result_valid),
		.bin_index    (bin_index),
		.cross_re     (cross_re),
		.cross_im     (cross_im),
		.power        (power),
		.last         (last)
	);

endmodule
